>>> hw/rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the depth to point cloud converter: transfer
// payloads, configuration bundle and register map.
// ----------------------------------------------------------------------------
package dpc_pkg;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_DEPTH_LIMIT     = 3'd1,
        REG_INVERSE_SCALE   = 3'd2,
        REG_CENTER_X        = 3'd3,
        REG_CENTER_Y        = 3'd4,
        REG_INVERSE_FOCAL_X = 3'd5,
        REG_INVERSE_FOCAL_Y = 3'd6
    } reg_index_t;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    // reset values of the configuration registers
    localparam logic [6:0]  RST_SAMPLE_INTERVAL = 7'd1;
    localparam logic [15:0] RST_DEPTH_LIMIT     = 16'd65535;
    localparam logic [23:0] RST_INVERSE_SCALE   = 24'd16777;
    localparam logic [15:0] RST_CENTER_X        = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y        = 16'd3840;
    localparam logic [23:0] RST_INVERSE_FOCAL   = 24'd32263;

    // pixel index bits resolved per remainder stage
    localparam int REM_STEP_BITS = 4;

    // fixed rounding of the ray and coordinate products
    localparam logic [39:0] RAY_HALF   = 40'd2048;
    localparam logic [58:0] COORD_HALF = 59'd32768;

    typedef struct packed {
        logic [6:0]  sample_interval;
        logic [15:0] depth_limit;
        logic [23:0] inverse_scale;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inverse_focal_x;
        logic [23:0] inverse_focal_y;
    } cfg_t;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [15:0] raw_depth;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } point_t;

endpackage

>>> hw/rtl/dpc_regs.sv
// ----------------------------------------------------------------------------
// dpc_regs
// APB-style configuration register file; every transfer completes at once.
// ----------------------------------------------------------------------------
module dpc_regs
    import dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_SAMPLE_INTERVAL: cfg_next.sample_interval = pwdata[6:0];
                REG_DEPTH_LIMIT:     cfg_next.depth_limit     = pwdata[15:0];
                REG_INVERSE_SCALE:   cfg_next.inverse_scale   = pwdata[23:0];
                REG_CENTER_X:        cfg_next.center_x        = pwdata[15:0];
                REG_CENTER_Y:        cfg_next.center_y        = pwdata[15:0];
                REG_INVERSE_FOCAL_X: cfg_next.inverse_focal_x = pwdata[23:0];
                REG_INVERSE_FOCAL_Y: cfg_next.inverse_focal_y = pwdata[23:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= RST_SAMPLE_INTERVAL;
            cfg_reg.depth_limit     <= RST_DEPTH_LIMIT;
            cfg_reg.inverse_scale   <= RST_INVERSE_SCALE;
            cfg_reg.center_x        <= RST_CENTER_X;
            cfg_reg.center_y        <= RST_CENTER_Y;
            cfg_reg.inverse_focal_x <= RST_INVERSE_FOCAL;
            cfg_reg.inverse_focal_y <= RST_INVERSE_FOCAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (index)
            REG_SAMPLE_INTERVAL: prdata = {25'd0, cfg_reg.sample_interval};
            REG_DEPTH_LIMIT:     prdata = {16'd0, cfg_reg.depth_limit};
            REG_INVERSE_SCALE:   prdata = {8'd0, cfg_reg.inverse_scale};
            REG_CENTER_X:        prdata = {16'd0, cfg_reg.center_x};
            REG_CENTER_Y:        prdata = {16'd0, cfg_reg.center_y};
            REG_INVERSE_FOCAL_X: prdata = {8'd0, cfg_reg.inverse_focal_x};
            REG_INVERSE_FOCAL_Y: prdata = {8'd0, cfg_reg.inverse_focal_y};
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/dpc_rem_stage.sv
// ----------------------------------------------------------------------------
// dpc_rem_stage
// Restoring remainder slice: shifts a few index bits into a partial
// remainder modulo the sampling interval, one compare and subtract per bit.
// ----------------------------------------------------------------------------
module dpc_rem_stage
    import dpc_pkg::*;
(
    input  logic [6:0]               rem_in,
    input  logic [REM_STEP_BITS-1:0] bits,
    input  logic [6:0]               divisor,
    output logic [6:0]               rem_out
);

    always_comb
    begin
        logic [7:0] trial;
        logic [6:0] part;
        part = rem_in;
        for (int i = REM_STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {part, bits[i]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            part = trial[6:0];
        end
        rem_out = part;
    end

endmodule

>>> hw/rtl/dpc_project.sv
// ----------------------------------------------------------------------------
// dpc_project
// Coordinate rounding: ray times depth product rounded half away from zero,
// sign applied and clipped to the signed 32-bit range.
// ----------------------------------------------------------------------------
module dpc_project
    import dpc_pkg::*;
(
    input  logic [58:0]        prod,
    input  logic               neg,
    output logic signed [31:0] coord
);

    logic [58:0] rounded;
    logic [42:0] mag;

    assign rounded = prod + COORD_HALF;
    assign mag     = rounded[58:16];

    // saturate magnitude then negate
    always_comb
    begin
        if (!neg)
        begin
            coord = (mag > 43'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(mag[31:0]);
        end
        else if (mag >= 43'h080000000)
        begin
            coord = 32'sh80000000;
        end
        else
        begin
            coord = signed'(32'd0 - mag[31:0]);
        end
    end

endmodule

>>> hw/rtl/depth_to_point_cloud.sv
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Pinhole back-projection of sampled depth pixels into colored 3D points.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  pixel     in         pixel_valid/pixel_stall  pixel_t
//  point     out        point_valid/point_stall  point_t
//  config    in         APB psel/penable         paddr, pwdata, prdata
//
//  one pixel per cycle while pixel_stall is low; a kept pixel passes from its
//  transfer through stage one to stage four and then into the output register,
//  which drives point
//  pixels off the sampling grid or with bad depth are dropped in stage three
//  reset clears the valid bits and loads the register reset values
//  a stalled output holds; bubbles in the pipe are filled before stalling
// ----------------------------------------------------------------------------
module depth_to_point_cloud
    import dpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel,
    output logic                  point_valid,
    input  logic                  point_stall,
    output point_t                point,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    localparam int          ZSHIFT = 24 - FRAC_BITS;
    localparam logic [40:0] ZHALF  = (41'd1 << ZSHIFT) >> 1;

    cfg_t       cfg;
    logic [6:0] interval;

    dpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // an interval of zero behaves as one
    assign interval = (cfg.sample_interval == 7'd0) ? 7'd1 : cfg.sample_interval;

    // ------------------------------------------------------------------
    // stage control: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv_out;
    logic keep;

    assign adv_out     = !out_valid_reg || !point_stall;
    assign adv4        = !s4_valid_reg || adv_out;
    assign adv3        = !s3_valid_reg || adv4;
    assign adv2        = !s2_valid_reg || adv3;
    assign adv1        = !s1_valid_reg || adv2;
    assign pixel_stall = !adv1;
    assign point_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)    s1_valid_reg  <= pixel_valid;
            if (adv2)    s2_valid_reg  <= s1_valid_reg;
            if (adv3)    s3_valid_reg  <= s2_valid_reg && keep;
            if (adv4)    s4_valid_reg  <= s3_valid_reg;
            if (adv_out) out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: top remainder bits, depth product, offsets from center
    // ------------------------------------------------------------------
    logic [6:0]  s1_rem_col_next, s1_rem_row_next;
    logic [6:0]  s1_rem_col_reg, s1_rem_row_reg;
    logic [7:0]  s1_col_reg, s1_row_reg;
    logic [39:0] s1_zprod_next, s1_zprod_reg;
    logic [15:0] pos_x, pos_y;
    logic        s1_negx_next, s1_negy_next, s1_negx_reg, s1_negy_reg;
    logic [15:0] s1_dx_next, s1_dy_next, s1_dx_reg, s1_dy_reg;
    logic        s1_depth_ok_next, s1_depth_ok_reg;
    logic [23:0] s1_rgb_reg;

    dpc_rem_stage u_rem_col1 (
        .rem_in  (7'd0),
        .bits    (pixel.pixel_col[11:8]),
        .divisor (interval),
        .rem_out (s1_rem_col_next)
    );

    dpc_rem_stage u_rem_row1 (
        .rem_in  (7'd0),
        .bits    (pixel.pixel_row[11:8]),
        .divisor (interval),
        .rem_out (s1_rem_row_next)
    );

    always_comb
    begin
        pos_x            = {pixel.pixel_col, 4'd0};
        pos_y            = {pixel.pixel_row, 4'd0};
        s1_negx_next     = cfg.center_x > pos_x;
        s1_negy_next     = cfg.center_y > pos_y;
        s1_dx_next       = s1_negx_next ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
        s1_dy_next       = s1_negy_next ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);
        s1_zprod_next    = {24'd0, pixel.raw_depth} * {16'd0, cfg.inverse_scale};
        s1_depth_ok_next = (pixel.raw_depth != 16'd0) &&
                           (pixel.raw_depth <= cfg.depth_limit);
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && pixel_valid)
        begin
            s1_rem_col_reg  <= s1_rem_col_next;
            s1_rem_row_reg  <= s1_rem_row_next;
            s1_col_reg      <= pixel.pixel_col[7:0];
            s1_row_reg      <= pixel.pixel_row[7:0];
            s1_zprod_reg    <= s1_zprod_next;
            s1_negx_reg     <= s1_negx_next;
            s1_negy_reg     <= s1_negy_next;
            s1_dx_reg       <= s1_dx_next;
            s1_dy_reg       <= s1_dy_next;
            s1_depth_ok_reg <= s1_depth_ok_next;
            s1_rgb_reg      <= {pixel.red_in, pixel.green_in, pixel.blue_in};
        end
    end

    // ------------------------------------------------------------------
    // stage 2: middle remainder bits, z rounding, ray products
    // ------------------------------------------------------------------
    logic [6:0]  s2_rem_col_next, s2_rem_row_next;
    logic [6:0]  s2_rem_col_reg, s2_rem_row_reg;
    logic [3:0]  s2_col_reg, s2_row_reg;
    logic [40:0] zround;
    logic [30:0] s2_z_next, s2_z_reg;
    logic [39:0] s2_rayx_next, s2_rayy_next, s2_rayx_reg, s2_rayy_reg;
    logic        s2_negx_reg, s2_negy_reg, s2_depth_ok_reg;
    logic [23:0] s2_rgb_reg;

    dpc_rem_stage u_rem_col2 (
        .rem_in  (s1_rem_col_reg),
        .bits    (s1_col_reg[7:4]),
        .divisor (interval),
        .rem_out (s2_rem_col_next)
    );

    dpc_rem_stage u_rem_row2 (
        .rem_in  (s1_rem_row_reg),
        .bits    (s1_row_reg[7:4]),
        .divisor (interval),
        .rem_out (s2_rem_row_next)
    );

    always_comb
    begin
        zround       = ({1'b0, s1_zprod_reg} + ZHALF) >> ZSHIFT;
        s2_z_next    = (zround > 41'h07FFFFFFF) ? 31'h7FFFFFFF : zround[30:0];
        s2_rayx_next = {24'd0, s1_dx_reg} * {16'd0, cfg.inverse_focal_x};
        s2_rayy_next = {24'd0, s1_dy_reg} * {16'd0, cfg.inverse_focal_y};
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_rem_col_reg  <= s2_rem_col_next;
            s2_rem_row_reg  <= s2_rem_row_next;
            s2_col_reg      <= s1_col_reg[3:0];
            s2_row_reg      <= s1_row_reg[3:0];
            s2_z_reg        <= s2_z_next;
            s2_rayx_reg     <= s2_rayx_next;
            s2_rayy_reg     <= s2_rayy_next;
            s2_negx_reg     <= s1_negx_reg;
            s2_negy_reg     <= s1_negy_reg;
            s2_depth_ok_reg <= s1_depth_ok_reg;
            s2_rgb_reg      <= s1_rgb_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: last remainder bits, keep decision, ray rounding to Q.16
    // ------------------------------------------------------------------
    logic [6:0]  rem_col, rem_row;
    logic [39:0] rayx_sum, rayy_sum;
    logic [27:0] s3_rayx_reg, s3_rayy_reg;
    logic [30:0] s3_z_reg;
    logic        s3_negx_reg, s3_negy_reg;
    logic [23:0] s3_rgb_reg;

    dpc_rem_stage u_rem_col3 (
        .rem_in  (s2_rem_col_reg),
        .bits    (s2_col_reg),
        .divisor (interval),
        .rem_out (rem_col)
    );

    dpc_rem_stage u_rem_row3 (
        .rem_in  (s2_rem_row_reg),
        .bits    (s2_row_reg),
        .divisor (interval),
        .rem_out (rem_row)
    );

    assign keep     = s2_depth_ok_reg && (rem_col == 7'd0) && (rem_row == 7'd0);
    assign rayx_sum = s2_rayx_reg + RAY_HALF;
    assign rayy_sum = s2_rayy_reg + RAY_HALF;

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_rayx_reg <= rayx_sum[39:12];
            s3_rayy_reg <= rayy_sum[39:12];
            s3_z_reg    <= s2_z_reg;
            s3_negx_reg <= s2_negx_reg;
            s3_negy_reg <= s2_negy_reg;
            s3_rgb_reg  <= s2_rgb_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: ray times depth
    // ------------------------------------------------------------------
    logic [58:0] s4_prodx_next, s4_prody_next, s4_prodx_reg, s4_prody_reg;
    logic [30:0] s4_z_reg;
    logic        s4_negx_reg, s4_negy_reg;
    logic [23:0] s4_rgb_reg;

    assign s4_prodx_next = {31'd0, s3_rayx_reg} * {28'd0, s3_z_reg};
    assign s4_prody_next = {31'd0, s3_rayy_reg} * {28'd0, s3_z_reg};

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_valid_reg)
        begin
            s4_prodx_reg <= s4_prodx_next;
            s4_prody_reg <= s4_prody_next;
            s4_z_reg     <= s3_z_reg;
            s4_negx_reg  <= s3_negx_reg;
            s4_negy_reg  <= s3_negy_reg;
            s4_rgb_reg   <= s3_rgb_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register: coordinate rounding and saturation
    // ------------------------------------------------------------------
    point_t             point_next, point_reg;
    logic signed [31:0] coord_x, coord_y;

    dpc_project u_proj_x (
        .prod  (s4_prodx_reg),
        .neg   (s4_negx_reg),
        .coord (coord_x)
    );

    dpc_project u_proj_y (
        .prod  (s4_prody_reg),
        .neg   (s4_negy_reg),
        .coord (coord_y)
    );

    always_comb
    begin
        point_next.point_x   = coord_x;
        point_next.point_y   = coord_y;
        point_next.point_z   = s4_z_reg;
        point_next.red_out   = s4_rgb_reg[23:16];
        point_next.green_out = s4_rgb_reg[15:8];
        point_next.blue_out  = s4_rgb_reg[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s4_valid_reg)
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

`ifndef SYNTHESIS
    // input stalls only while the first stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> s1_valid_reg)
        else $error("pixel stalled with an empty first stage");

    // a new output transfer always comes from a full last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_valid_reg))
        else $error("output valid without a source item");

    // a blocked last stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !adv_out |=> s4_valid_reg && $stable(s4_prodx_reg)
            && $stable(s4_prody_reg))
        else $error("last stage lost its item under stall");
`endif

endmodule
